[rtl/pip_pkg.sv]
// Shared types and constants for the point-in-polygon test unit.
// No dependencies; used by every module under rtl/.
package pip_pkg;

  // Field widths
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;

  // Default polygon capacity
  localparam int MAX_VERTICES_DEF = 64;

  // Command word op codes
  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  // One stored vertex, or the query point
  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } vertex_t;

  // Control that travels with each edge through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } edge_tag_t;

endpackage

[rtl/pip_vertex_ram.sv]
// Vertex store: one write port, one read port, registered read data.
// Depends on pip_pkg for the vertex word type.
module pip_vertex_ram #(
  parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pip_pkg::vertex_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output pip_pkg::vertex_t rdata
);

  pip_pkg::vertex_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pip_edge_unit.sv]
// Three-stage edge crossing pipeline: differences, products, compare.
// Depends on pip_pkg for vertex and tag types.
module pip_edge_unit (
  input  logic                clk,
  input  logic                rst,
  input  pip_pkg::edge_tag_t  in_tag,
  input  pip_pkg::vertex_t    pt,
  input  pip_pkg::vertex_t    vi,
  input  pip_pkg::vertex_t    vj,
  output pip_pkg::edge_tag_t  out_tag,
  output logic                flip
);

  localparam int DLAT_W = pip_pkg::LAT_W + 1;
  localparam int DLON_W = pip_pkg::LON_W + 1;
  localparam int PROD_W = DLAT_W + DLON_W;

  // stage A registers
  pip_pkg::edge_tag_t        a_tag;
  logic                      a_straddle;
  logic                      a_pos;
  logic signed [DLON_W-1:0]  a_dx;
  logic signed [DLAT_W-1:0]  a_dlat;
  logic signed [DLON_W-1:0]  a_dxe;
  logic signed [DLAT_W-1:0]  a_dy;

  // stage B registers
  pip_pkg::edge_tag_t        b_tag;
  logic                      b_straddle;
  logic                      b_pos;
  logic signed [PROD_W-1:0]  b_lhs;
  logic signed [PROD_W-1:0]  b_rhs;

  logic straddle;

  // edge spans the point's latitude: one end <= lat < other end
  assign straddle = ((vi.lat <= pt.lat) && (pt.lat < vj.lat)) ||
                    ((vj.lat <= pt.lat) && (pt.lat < vi.lat));

  // control pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag   <= '0;
      b_tag   <= '0;
      out_tag <= '0;
    end else begin
      a_tag   <= in_tag;
      b_tag   <= a_tag;
      out_tag <= b_tag;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // differences
    a_straddle <= straddle;
    a_pos      <= vj.lat > vi.lat;
    a_dx       <= DLON_W'(pt.lon) - DLON_W'(vi.lon);
    a_dlat     <= DLAT_W'(vj.lat) - DLAT_W'(vi.lat);
    a_dxe      <= DLON_W'(vj.lon) - DLON_W'(vi.lon);
    a_dy       <= DLAT_W'(pt.lat) - DLAT_W'(vi.lat);
    // cross products
    b_straddle <= a_straddle;
    b_pos      <= a_pos;
    b_lhs      <= PROD_W'(a_dx) * PROD_W'(a_dlat);
    b_rhs      <= PROD_W'(a_dxe) * PROD_W'(a_dy);
    // sign-corrected compare
    flip       <= b_straddle && (b_pos ? (b_lhs < b_rhs) : (b_lhs > b_rhs));
  end

endmodule

[rtl/point_in_polygon_test_unit.sv]
// Top level of the crossing-number point-in-polygon test unit.
// Depends on pip_pkg, pip_vertex_ram and pip_edge_unit.
//
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. op = 0 writes (lat, lon) into slot vertex_index; slots at or above
//   MAX_VERTICES are dropped. op = 1 queries point (lat, lon).
//   Result: done is high for one cycle with inside_res; it cannot be stalled.
//   Config channel: cfg_valid/cfg_ready write vertex_count (cfg_ready is
//   always high); write it only while the unit is idle. Counts above
//   MAX_VERTICES are treated as MAX_VERTICES.
//   Sequence: a query over n vertices reads n + 1 words from the vertex RAM,
//   one per cycle, then drains the three-stage edge pipeline; done then rises
//   and busy is high until then. With n = 0 done follows in the next cycle
//   without busy. A vertex write keeps busy low and may be followed at once.
//   Reset: clears the count and the sequencer; the vertex RAM is not cleared
//   and must be written before it is queried.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [0:0]                      op,
  input  logic [pip_pkg::IDX_W-1:0]       vertex_index,
  input  logic signed [pip_pkg::LAT_W-1:0] lat,
  input  logic signed [pip_pkg::LON_W-1:0] lon,
  output logic                            done,
  output logic [0:0]                      inside_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]       cfg_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > pip_pkg::CNT_W) ? CW : pip_pkg::CNT_W;
  localparam int IW = (AW > pip_pkg::IDX_W) ? AW : pip_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  state_t                     state;
  logic [pip_pkg::CNT_W-1:0]  vertex_count;
  logic [CW-1:0]              n_sat;
  logic [CW-1:0]              cnt;
  pip_pkg::vertex_t           point;
  pip_pkg::vertex_t           prev;
  logic                       parity;
  logic                       rd_valid;
  logic                       rd_edge;
  logic                       rd_last;

  logic                       accept;
  logic [NW-1:0]              count_ext;
  logic [CW-1:0]              count_sat;
  logic [IW-1:0]              widx;
  logic                       wr_en;
  logic [AW-1:0]              rd_addr;
  logic [CW-1:0]              cnt_m1;
  logic [CW-1:0]              n_m1;
  logic                       rd_en;
  pip_pkg::vertex_t           in_word;
  pip_pkg::vertex_t           rdata;
  pip_pkg::edge_tag_t         e_in;
  pip_pkg::edge_tag_t         e_out;
  logic                       e_cross;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // count saturated to capacity
  assign count_ext = NW'(vertex_count);
  assign count_sat = (count_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                     : CW'(count_ext);

  // vertex write decode
  assign in_word.lat = lat;
  assign in_word.lon = lon;
  assign widx  = IW'(vertex_index);
  assign wr_en = accept && (op == pip_pkg::OP_WRITE) &&
                 (32'(vertex_index) < MAX_VERTICES);

  // walk address: vertex n-1 first, then 0 .. n-1
  assign cnt_m1  = cnt - 1'b1;
  assign n_m1    = n_sat - 1'b1;
  assign rd_addr = (cnt == '0) ? n_m1[AW-1:0] : cnt_m1[AW-1:0];
  assign rd_en   = (state == S_WALK);

  pip_vertex_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (widx[AW-1:0]),
    .wdata (in_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // edge (i, j): i from the RAM, j the word read before it
  assign e_in.valid = rd_valid && rd_edge;
  assign e_in.last  = rd_last;

  pip_edge_unit u_edge (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (e_in),
    .pt      (point),
    .vi      (rdata),
    .vj      (prev),
    .out_tag (e_out),
    .flip    (e_cross)
  );

  // previous vertex holder
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev <= rdata;
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_valid   <= 1'b0;
      rd_edge    <= 1'b0;
      rd_last    <= 1'b0;
      cnt        <= '0;
      n_sat      <= '0;
      parity     <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= rd_en;
      rd_edge  <= (cnt != '0);
      rd_last  <= (cnt == n_sat);
      if (e_out.valid && e_cross) begin
        parity <= !parity;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (op == pip_pkg::OP_QUERY)) begin
            point  <= in_word;
            n_sat  <= count_sat;
            cnt    <= '0;
            parity <= 1'b0;
            if (count_sat == '0) begin
              done       <= 1'b1;
              inside_res <= 1'b0;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          cnt <= cnt + 1'b1;
          if (cnt == n_sat) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (e_out.valid && e_out.last) begin
            done       <= 1'b1;
            inside_res <= parity ^ e_cross;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/pip_tb_pkg.sv]
// Constants shared by the checker and the testbench top of the point-in-polygon unit.
// Depends on pip_pkg for the default polygon capacity.
package pip_tb_pkg;

  // Bound on the longest query: full polygon walk and pipeline drain
  localparam int QUERY_DRAIN_CYC = pip_pkg::MAX_VERTICES_DEF + 6;

endpackage

[dv/pip_checker.sv]
// Checker for the point-in-polygon unit: mirrors the vertex store and the count,
// predicts the inside flag of each query and compares it with the result word.
// Depends on pip_pkg and pip_tb_pkg.
module pip_checker
  import pip_pkg::*;
  import pip_tb_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [0:0]              op,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [LAT_W-1:0] lat,
  input  logic signed [LON_W-1:0] lon,
  input  logic                    done,
  input  logic [0:0]              inside_res,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the polygon and the vertex count
  logic signed [LAT_W-1:0] poly_lat [MAX_VERTICES];
  logic signed [LON_W-1:0] poly_lon [MAX_VERTICES];
  logic [CNT_W-1:0]        poly_count = '0;

  // Inside flags of queries taken but not yet answered, oldest first
  logic [0:0] inside_flags_q [$];
  logic [0:0] want_flag;
  int         errs = 0;

  // Does edge (i, j) flip the parity for point (py, px)?
  function automatic bit edge_flips(longint py, longint px, longint yi, longint xi,
                                    longint yj, longint xj);
    longint dlat, lhs, rhs;
    if (!(((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi))))
      return 1'b0;
    dlat = yj - yi;
    lhs  = (px - xi) * dlat;
    rhs  = (xj - xi) * (py - yi);
    // sign of dlat decides the sense of the cross-multiplied compare
    return (dlat > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Crossing-number parity over the vertices in use
  function automatic logic [0:0] crossing_parity(logic signed [LAT_W-1:0] py,
                                                 logic signed [LON_W-1:0] px);
    int         n;
    int         j;
    logic [0:0] flag;
    flag = 1'b0;
    n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    j    = n - 1;
    for (int i = 0; i < n; i++) begin
      if (edge_flips($signed(py), $signed(px), $signed(poly_lat[i]), $signed(poly_lon[i]),
                     $signed(poly_lat[j]), $signed(poly_lon[j])))
        flag = ~flag;
      j = i;
    end
    return flag;
  endfunction

  // Watch all channels on each edge
  always @(posedge clk) begin
    if (rst) begin
      poly_count = '0;
      inside_flags_q.delete();
    end else begin
      // result word: compare against the oldest pending query
      if (done) begin
        if (inside_flags_q.size() == 0) begin
          $error("result word with no query pending, inside_res %0d", inside_res);
          errs++;
        end else begin
          want_flag = inside_flags_q.pop_front();
          if (inside_res !== want_flag) begin
            $error("inside_res mismatch: expected %0d, actual %0d", want_flag, inside_res);
            errs++;
          end
        end
      end
      // config word
      if (cfg_valid && cfg_ready)
        poly_count = cfg_data;
      // command word
      if (start && !busy) begin
        if (op == OP_WRITE) begin
          if (vertex_index < MAX_VERTICES) begin
            poly_lat[vertex_index] = lat;
            poly_lon[vertex_index] = lon;
          end
        end else begin
          inside_flags_q.push_back(crossing_parity(lat, lon));
        end
      end
    end
    fail_count <= errs;
    pending    <= inside_flags_q.size();
  end

endmodule

[dv/tb_top.sv]
// Testbench top for point_in_polygon_test_unit: drives command and config words,
// loads polygons, issues queries and gives the verdict from the checker's count.
// Depends on pip_pkg, pip_tb_pkg, pip_checker and the unit's RTL.
module tb_top;
  import pip_pkg::*;
  import pip_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_V       = MAX_VERTICES_DEF;
  localparam int ITEM_TARGET = 400;

  localparam logic signed [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic signed [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic signed [LON_W-1:0] LON_MIN = {1'b1, {(LON_W-1){1'b0}}};
  localparam logic signed [LON_W-1:0] LON_MAX = {1'b0, {(LON_W-1){1'b1}}};

  // How a phase draws its coordinates
  typedef enum int {MODE_GRID, MODE_BOX, MODE_FULL} coord_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [0:0]              op = OP_WRITE;
  logic [IDX_W-1:0]        vertex_index = '0;
  logic signed [LAT_W-1:0] lat = '0;
  logic signed [LON_W-1:0] lon = '0;
  logic                    done;
  logic [0:0]              inside_res;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data = '0;

  int fail_count;
  int pending;

  // Stimulus bookkeeping: what was written where, to aim queries at vertices
  logic signed [LAT_W-1:0] vlat [MAX_V];
  logic signed [LON_W-1:0] vlon [MAX_V];
  bit                      written [MAX_V];
  int                      items_sent = 0;
  bit                      no_idle = 1'b0;
  int                      used = 0;

  // Coordinate drawing state for the current phase
  coord_mode_t coord_mode = MODE_BOX;
  longint      c_lat = 0;
  longint      c_lon = 0;
  int          box_span = 1000;
  int          grid_step = 100;

  point_in_polygon_test_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .vertex_index (vertex_index),
    .lat          (lat),
    .lon          (lon),
    .done         (done),
    .inside_res   (inside_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  pip_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .vertex_index (vertex_index),
    .lat          (lat),
    .lon          (lon),
    .done         (done),
    .inside_res   (inside_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #10 clk = ~clk;

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Coordinate draws for the current phase
  function automatic logic signed [LAT_W-1:0] pick_lat();
    longint v;
    case (coord_mode)
      MODE_GRID: v = c_lat + (longint'($urandom_range(0, 6)) - 3) * grid_step;
      MODE_BOX:  v = c_lat + longint'($urandom_range(0, 2 * box_span)) - box_span;
      default:   v = longint'($urandom());
    endcase
    return v[LAT_W-1:0];
  endfunction

  function automatic logic signed [LON_W-1:0] pick_lon();
    longint v;
    case (coord_mode)
      MODE_GRID: v = c_lon + (longint'($urandom_range(0, 6)) - 3) * grid_step;
      MODE_BOX:  v = c_lon + longint'($urandom_range(0, 2 * box_span)) - box_span;
      default:   v = longint'($urandom());
    endcase
    return v[LON_W-1:0];
  endfunction

  // One command word: random hold-off, then hold until taken
  task automatic send_cmd(input logic [0:0] c_op, input logic [IDX_W-1:0] c_idx,
                          input logic signed [LAT_W-1:0] c_lat,
                          input logic signed [LON_W-1:0] c_lon);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    op           <= c_op;
    vertex_index <= c_idx;
    lat          <= c_lat;
    lon          <= c_lon;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_vertex(input int slot, input logic signed [LAT_W-1:0] v_lat,
                              input logic signed [LON_W-1:0] v_lon);
    send_cmd(OP_WRITE, slot[IDX_W-1:0], v_lat, v_lon);
    vlat[slot]    = v_lat;
    vlon[slot]    = v_lon;
    written[slot] = 1'b1;
  endtask

  // vertex_index is ignored by a query, so it carries noise
  task automatic query_point(input logic signed [LAT_W-1:0] q_lat,
                             input logic signed [LON_W-1:0] q_lon);
    send_cmd(OP_QUERY, IDX_W'($urandom_range(0, MAX_V - 1)), q_lat, q_lon);
  endtask

  // Stop sending, wait for every answer, then let the pipeline settle
  task automatic drain_unit();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUERY_DRAIN_CYC) @(posedge clk);
  endtask

  // Config word, only with the unit idle
  task automatic set_vertex_count(input int n);
    drain_unit();
    cfg_valid <= 1'b1;
    cfg_data  <= n[CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Query aimed at vertices now and then to hit the boundary cases
  task automatic random_query();
    int r;
    int k;
    r = $urandom_range(0, 7);
    k = (used > 0) ? $urandom_range(0, used - 1) : 0;
    if (used > 0 && r == 0)
      query_point(vlat[k], vlon[k]);
    else if (used > 0 && r == 1)
      query_point(vlat[k], pick_lon());
    else if (used > 0 && r == 2)
      query_point(pick_lat(), vlon[k]);
    else if (r == 3)
      query_point(LAT_W'($urandom()), $urandom());
    else
      query_point(pick_lat(), pick_lon());
  endtask

  initial begin
    int n;
    int r;
    int phase;
    int nq;
    for (int k = 0; k < MAX_V; k++) written[k] = 1'b0;

    // reset
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty polygon with extreme points
    set_vertex_count(0);
    query_point(LAT_MIN, LON_MIN);
    query_point(LAT_MAX, LON_MAX);

    // directed: square, first as one and two vertices, then whole
    write_vertex(0, 0, 0);
    write_vertex(1, 0, 1000);
    write_vertex(2, 1000, 1000);
    write_vertex(3, 1000, 0);
    set_vertex_count(1);
    query_point(500, 500);
    set_vertex_count(2);
    query_point(0, 500);
    query_point(500, -10);
    set_vertex_count(4);
    query_point(500, 500);
    query_point(500, 1500);
    query_point(0, 500);      // on the lower horizontal edge
    query_point(1000, 500);   // on the upper horizontal edge
    query_point(500, 0);      // exactly on the crossing, left side
    query_point(500, 1000);   // exactly on the crossing, right side
    query_point(0, 0);        // on a vertex

    // directed: triangle spanning the full field widths
    write_vertex(0, LAT_MIN, LON_MIN);
    write_vertex(1, LAT_MAX, LON_MIN);
    write_vertex(2, 0, LON_MAX);
    set_vertex_count(3);
    query_point(0, 0);
    query_point(-1, LON_MIN);
    query_point(LAT_MAX, LON_MAX);

    // random phases: load a polygon, set the count, then query it
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0)
        n = 127;
      else if (phase == 1)
        n = MAX_V;
      else begin
        r = $urandom_range(0, 15);
        if (r == 0)
          n = $urandom_range(MAX_V, 127);
        else if (r <= 2)
          n = $urandom_range(0, 2);
        else
          n = $urandom_range(3, 12);
      end
      used = (n > MAX_V) ? MAX_V : n;

      if (phase == 0)
        coord_mode = MODE_FULL;
      else begin
        r = $urandom_range(0, 7);
        coord_mode = (r < 3) ? MODE_GRID : (r < 7) ? MODE_BOX : MODE_FULL;
      end
      c_lat     = longint'($urandom_range(0, 1200000000)) - 600000000;
      c_lon     = longint'($urandom_range(0, 2400000000)) - 1200000000;
      box_span  = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 2000)
                                              : $urandom_range(1, 300000000);
      grid_step = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 100)
                                              : $urandom_range(1, 100000000);
      no_idle   = ($urandom_range(0, 3) == 0);

      // small polygons are rewritten whole, large ones where unwritten and at random
      for (int k = 0; k < used; k++) begin
        if (!written[k] || used <= 16 || $urandom_range(0, 7) == 0)
          write_vertex(k, pick_lat(), pick_lon());
      end
      // noise: a slot that this count never reads
      if (used < MAX_V && $urandom_range(0, 2) == 0)
        write_vertex($urandom_range(used, MAX_V - 1), LAT_W'($urandom()), $urandom());

      set_vertex_count(n);

      nq = $urandom_range(4, 12);
      repeat (nq) begin
        if (used > 0 && $urandom_range(0, 9) == 0)
          write_vertex($urandom_range(0, used - 1), pick_lat(), pick_lon());
        random_query();
      end
      phase++;
    end

    // wrap up
    drain_unit();
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/pip_pkg.sv
rtl/pip_vertex_ram.sv
rtl/pip_edge_unit.sv
rtl/point_in_polygon_test_unit.sv
dv/pip_tb_pkg.sv
dv/pip_checker.sv
dv/tb_top.sv
